>>> rtl/audio_buffer_release_tracker_unit_defines.svh
// ----------------------------------------------------------------------------
// Audio buffer release tracker assertion macros
// Shared property templates for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef AUDIO_BUFFER_RELEASE_TRACKER_UNIT_DEFINES_SVH
`define AUDIO_BUFFER_RELEASE_TRACKER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and muted while arst_n is low.
`define ABRT_ASSERT_IMPL(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("abrt port check failed");

// Next-cycle implication, sampled on clk and muted while arst_n is low.
`define ABRT_ASSERT_NEXT(name, pre, post) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("abrt port check failed");

`endif

>>> rtl/abrt_pkg.sv
// ----------------------------------------------------------------------------
// Audio buffer release tracker package
// Field widths, command codes, result type and shared constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package abrt_pkg;

	localparam int unsigned TAG_W       = 64;
	localparam int unsigned LEN_W       = 20;
	localparam int unsigned POS_W       = 48;
	localparam int unsigned MAXPOP_W    = 5;
	localparam int unsigned DEPTH_DEF   = 16;

	localparam logic [MAXPOP_W-1:0] MAX_RESULTS = 5'd16;
	localparam logic [POS_W-1:0]    POS_MAX     = 48'hFFFF_FFFF_FFFF;

	// floor(x / 12) == (x * DIV12_MUL) >> DIV12_SHIFT for every x below 2^21.
	localparam int unsigned        DIV12_SHIFT = 24;
	localparam int unsigned        DIV12_MUL_W = 21;
	localparam logic [DIV12_MUL_W-1:0] DIV12_MUL = 21'd1398102;

	typedef enum logic [1:0] {
		CMD_APPEND   = 2'd0,
		CMD_CHECK    = 2'd1,
		CMD_GET      = 2'd2,
		CMD_CONTAINS = 2'd3
	} cmd_t;

	typedef struct packed {
		logic [TAG_W-1:0] out_tag;
		logic             tag_valid;
		logic             found;
		logic             any_released;
		logic             overflow;
		logic             last;
	} result_t;

endpackage

>>> rtl/abrt_req_if.sv
// ----------------------------------------------------------------------------
// Command channel
// Carries one command beat per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abrt_req_if;
	logic                            valid;
	logic                            ready;
	logic [1:0]                      cmd;
	logic [abrt_pkg::TAG_W-1:0]      buffer_tag;
	logic [abrt_pkg::LEN_W-1:0]      sample_length;
	logic [abrt_pkg::POS_W-1:0]      play_position;
	logic [abrt_pkg::MAXPOP_W-1:0]   max_pop;

	modport source (
		output valid, cmd, buffer_tag, sample_length, play_position, max_pop,
		input  ready
	);
	modport sink (
		input  valid, cmd, buffer_tag, sample_length, play_position, max_pop,
		output ready
	);
endinterface

>>> rtl/abrt_rsp_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Carries one result beat per valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abrt_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [abrt_pkg::TAG_W-1:0] out_tag;
	logic                       tag_valid;
	logic                       found;
	logic                       any_released;
	logic                       overflow;
	logic                       last;

	modport source (
		output valid, out_tag, tag_valid, found, any_released, overflow, last,
		input  ready
	);
	modport sink (
		input  valid, out_tag, tag_valid, found, any_released, overflow, last,
		output ready
	);
endinterface

>>> rtl/abrt_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration write channel
// Carries the surround mode register value on each write beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface abrt_cfg_if;
	logic valid;
	logic ready;
	logic surround_mode;

	modport source (output valid, surround_mode, input ready);
	modport sink (input valid, surround_mode, output ready);
endinterface

>>> rtl/abrt_mem.sv
// ----------------------------------------------------------------------------
// Descriptor store
// Tag and end position memories with one write port and one shared,
// registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrt_mem #(
	parameter int unsigned QUEUE_DEPTH = abrt_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                wr_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
	input  logic [abrt_pkg::TAG_W-1:0]          wr_tag,
	input  logic [abrt_pkg::POS_W-1:0]          wr_end,
	input  logic                                rd_en,
	input  logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
	output logic [abrt_pkg::TAG_W-1:0]          rd_tag,
	output logic [abrt_pkg::POS_W-1:0]          rd_end
);

	logic [abrt_pkg::TAG_W-1:0] tag_mem [QUEUE_DEPTH];
	logic [abrt_pkg::POS_W-1:0] end_mem [QUEUE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tag_mem[wr_addr] <= wr_tag;
			end_mem[wr_addr] <= wr_end;
		end
	end

	// Read data holds between reads so a stalled consumer sees it unchanged.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_tag <= tag_mem[rd_addr];
			rd_end <= end_mem[rd_addr];
		end
	end

endmodule

>>> rtl/abrt_outreg.sv
// ----------------------------------------------------------------------------
// Result output register
// Holds one result beat and decouples the sequencer from the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrt_outreg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  abrt_pkg::result_t  res_in,
	output logic               free,
	abrt_rsp_if.source         rsp
);

	logic              valid_q;
	abrt_pkg::result_t res_q;

	assign free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			res_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			res_q   <= res_in;
		end else if (rsp.ready) begin
			valid_q <= 1'b0;
		end
	end

	assign rsp.valid        = valid_q;
	assign rsp.out_tag      = res_q.out_tag;
	assign rsp.tag_valid    = res_q.tag_valid;
	assign rsp.found        = res_q.found;
	assign rsp.any_released = res_q.any_released;
	assign rsp.overflow     = res_q.overflow;
	assign rsp.last         = res_q.last;

endmodule

>>> rtl/abrt_ctrl.sv
// ----------------------------------------------------------------------------
// Queue sequencer
// Decodes commands, keeps the ring pointers and released marks, and walks
// the descriptor store through its registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module abrt_ctrl #(
	parameter int unsigned QUEUE_DEPTH = abrt_pkg::DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	abrt_req_if.sink                            req,
	input  logic                                surround,
	output logic                                wr_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0]      wr_addr,
	output logic [abrt_pkg::TAG_W-1:0]          wr_tag,
	output logic [abrt_pkg::POS_W-1:0]          wr_end,
	output logic                                rd_en,
	output logic [$clog2(QUEUE_DEPTH)-1:0]      rd_addr,
	input  logic [abrt_pkg::TAG_W-1:0]          rd_tag,
	input  logic [abrt_pkg::POS_W-1:0]          rd_end,
	input  logic                                out_free,
	output logic                                out_load,
	output abrt_pkg::result_t                   out_res
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned SUM_W = CNT_W + 1;
	localparam int unsigned PROD_W = abrt_pkg::LEN_W + abrt_pkg::DIV12_MUL_W;
	localparam int unsigned QUOT_W = PROD_W - abrt_pkg::DIV12_SHIFT;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE,
		S_APP_WR,
		S_CHK,
		S_GET,
		S_GET_DATA,
		S_CON,
		S_EMIT
	} state_t;

	function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] i);
		return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
	endfunction

	function automatic logic [IDX_W-1:0] idx_prev(input logic [IDX_W-1:0] i);
		return (i == '0) ? LAST_IDX : i - IDX_W'(1);
	endfunction

	// Single final beat of a command without a popped tag.
	function automatic abrt_pkg::result_t done_res(input logic fnd, input logic rel,
			input logic ovf);
		abrt_pkg::result_t r;
		r              = '0;
		r.found        = fnd;
		r.any_released = rel;
		r.overflow     = ovf;
		r.last         = 1'b1;
		return r;
	endfunction

	state_t                        state_q;
	logic [IDX_W-1:0]              oldest_q;
	logic [IDX_W-1:0]              newest_q;
	logic [CNT_W-1:0]              count_q;
	logic [QUEUE_DEPTH-1:0]        rel_q;
	logic [abrt_pkg::TAG_W-1:0]    tag_q;
	logic [abrt_pkg::LEN_W-1:0]    len_q;
	logic [abrt_pkg::POS_W-1:0]    pos_q;
	logic [abrt_pkg::MAXPOP_W-1:0] pop_left_q;
	logic                          popped_q;
	logic [IDX_W-1:0]              cur_q;
	logic [CNT_W-1:0]              issue_cnt_q;
	logic                          flag_q;
	abrt_pkg::result_t             res_q;
	logic                          v_s1;
	logic [IDX_W-1:0]              slot_s1;
	logic                          pop_last_s1;

	logic [PROD_W-1:0]             len_prod;
	logic [QUOT_W-1:0]             len_quot;
	logic [abrt_pkg::LEN_W-1:0]    len_scaled;
	logic [abrt_pkg::MAXPOP_W-1:0] pop_limit;
	logic [SUM_W-1:0]              slot_sum;
	logic [SUM_W-1:0]              slot_wrap;
	logic [IDX_W-1:0]              app_slot;
	logic [abrt_pkg::POS_W:0]      end_sum;
	logic [abrt_pkg::POS_W-1:0]    end_calc;
	logic                          chk_issue;
	logic                          con_hit;
	logic                          con_issue;
	logic                          can_pop;
	logic                          walk_rd;

	// Surround tracks store floor(len / 12) * 4 samples.
	assign len_prod   = PROD_W'(req.sample_length) * PROD_W'(abrt_pkg::DIV12_MUL);
	assign len_quot   = len_prod[PROD_W-1:abrt_pkg::DIV12_SHIFT];
	assign len_scaled = surround ? abrt_pkg::LEN_W'({len_quot, 2'b00}) : req.sample_length;
	assign pop_limit  = (req.max_pop > abrt_pkg::MAX_RESULTS) ? abrt_pkg::MAX_RESULTS
		: req.max_pop;

	assign slot_sum  = SUM_W'(oldest_q) + SUM_W'(count_q);
	assign slot_wrap = (slot_sum >= SUM_W'(QUEUE_DEPTH)) ? slot_sum - SUM_W'(QUEUE_DEPTH)
		: slot_sum;
	assign app_slot  = slot_wrap[IDX_W-1:0];

	assign end_sum  = {1'b0, rd_end} + (abrt_pkg::POS_W + 1)'(len_q);
	assign end_calc = (count_q == '0) ? abrt_pkg::POS_W'(len_q)
		: (end_sum[abrt_pkg::POS_W] ? abrt_pkg::POS_MAX : end_sum[abrt_pkg::POS_W-1:0]);

	assign chk_issue = (state_q == S_CHK) && (issue_cnt_q != count_q);
	assign con_hit   = (state_q == S_CON) && v_s1 && (rd_tag == tag_q);
	// The contains walk stops at a released entry, once a match is seen, or after every queued entry.
	assign con_issue = (state_q == S_CON) && (issue_cnt_q != count_q) && !flag_q
		&& !con_hit && !rel_q[cur_q];
	assign can_pop   = (state_q == S_GET) && (pop_left_q != '0) && (count_q != '0)
		&& rel_q[oldest_q];
	assign walk_rd   = chk_issue || con_issue;

	assign req.ready = (state_q == S_IDLE);

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = newest_q;
		wr_en   = 1'b0;
		wr_addr = app_slot;
		wr_tag  = tag_q;
		wr_end  = end_calc;
		case (state_q)
			S_IDLE: begin
				// Prefetch the newest end position for a following append.
				rd_en = 1'b1;
			end
			S_APP_WR: begin
				wr_en = 1'b1;
			end
			S_CHK, S_CON: begin
				rd_en   = walk_rd;
				rd_addr = cur_q;
			end
			S_GET: begin
				rd_en   = can_pop;
				rd_addr = oldest_q;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		out_res  = res_q;
		out_load = 1'b0;
		case (state_q)
			S_EMIT: begin
				out_load = out_free;
			end
			S_GET_DATA: begin
				out_res           = '0;
				out_res.out_tag   = rd_tag;
				out_res.tag_valid = 1'b1;
				out_res.last      = pop_last_s1;
				out_load          = out_free;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			oldest_q    <= '0;
			newest_q    <= '0;
			count_q     <= '0;
			rel_q       <= '0;
			tag_q       <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			pop_left_q  <= '0;
			popped_q    <= 1'b0;
			cur_q       <= '0;
			issue_cnt_q <= '0;
			flag_q      <= 1'b0;
			res_q       <= '0;
			v_s1        <= 1'b0;
			slot_s1     <= '0;
			pop_last_s1 <= 1'b0;
		end else begin
			v_s1    <= walk_rd;
			slot_s1 <= cur_q;
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						tag_q       <= req.buffer_tag;
						len_q       <= len_scaled;
						pos_q       <= req.play_position;
						issue_cnt_q <= '0;
						flag_q      <= 1'b0;
						case (abrt_pkg::cmd_t'(req.cmd))
							abrt_pkg::CMD_APPEND: begin
								if (count_q == FULL_CNT) begin
									res_q   <= done_res(1'b0, 1'b0, 1'b1);
									state_q <= S_EMIT;
								end else begin
									state_q <= S_APP_WR;
								end
							end
							abrt_pkg::CMD_CHECK: begin
								cur_q   <= oldest_q;
								state_q <= S_CHK;
							end
							abrt_pkg::CMD_GET: begin
								pop_left_q <= pop_limit;
								popped_q   <= 1'b0;
								state_q    <= S_GET;
							end
							abrt_pkg::CMD_CONTAINS: begin
								cur_q   <= newest_q;
								state_q <= S_CON;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				S_APP_WR: begin
					rel_q[app_slot] <= 1'b0;
					newest_q        <= app_slot;
					count_q         <= count_q + CNT_W'(1);
					res_q           <= done_res(1'b0, 1'b0, 1'b0);
					state_q         <= S_EMIT;
				end
				S_CHK: begin
					if (chk_issue) begin
						cur_q       <= idx_next(cur_q);
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
					end
					if (v_s1 && !rel_q[slot_s1] && (rd_end <= pos_q)) begin
						rel_q[slot_s1] <= 1'b1;
						flag_q         <= 1'b1;
					end
					if (!chk_issue && !v_s1) begin
						res_q   <= done_res(1'b0, flag_q, 1'b0);
						state_q <= S_EMIT;
					end
				end
				S_GET: begin
					if (can_pop) begin
						// The next pop is known now, so the final tag carries last.
						pop_last_s1      <= (pop_left_q == abrt_pkg::MAXPOP_W'(1))
							|| (count_q == CNT_W'(1)) || !rel_q[idx_next(oldest_q)];
						rel_q[oldest_q]  <= 1'b0;
						oldest_q         <= idx_next(oldest_q);
						count_q          <= count_q - CNT_W'(1);
						pop_left_q       <= pop_left_q - abrt_pkg::MAXPOP_W'(1);
						popped_q         <= 1'b1;
						state_q          <= S_GET_DATA;
					end else if (popped_q) begin
						state_q <= S_IDLE;
					end else begin
						res_q   <= done_res(1'b0, 1'b0, 1'b0);
						state_q <= S_EMIT;
					end
				end
				S_GET_DATA: begin
					if (out_free) begin
						state_q <= pop_last_s1 ? S_IDLE : S_GET;
					end
				end
				S_CON: begin
					if (con_issue) begin
						cur_q       <= idx_prev(cur_q);
						issue_cnt_q <= issue_cnt_q + CNT_W'(1);
					end
					if (con_hit) begin
						flag_q <= 1'b1;
					end
					if (!con_issue && !v_s1) begin
						res_q   <= done_res(flag_q, 1'b0, 1'b0);
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/audio_buffer_release_tracker_unit.sv
// ----------------------------------------------------------------------------
// Audio buffer release tracker
// Ring queue of submitted audio buffer descriptors with release tracking.
//
// Commands arrive on the req channel, one beat per command. Append, check
// and contains answer with exactly one rsp beat marked last; get answers with
// one beat per popped tag, the final one marked last, or a single empty beat
// when nothing is released at the oldest end or max_pop is zero. The cfg
// channel writes the surround mode bit and is always ready; write it only
// while idle. One command is in flight at a time, and throughput is set by
// walks over the single read port of the descriptor store: check and
// contains read one entry per cycle, and get waits for the result register
// to free before it pops each further tag.
// A result register sits on rsp: the next command is taken while the last
// result still waits, and a stalled receiver only holds back the next result.
// Reset empties the queue, clears all released marks and the surround bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_buffer_release_tracker_unit #(
	parameter int unsigned QUEUE_DEPTH = abrt_pkg::DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	abrt_req_if.sink    req,
	abrt_rsp_if.source  rsp,
	abrt_cfg_if.sink    cfg
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

	logic                       surround_q;
	logic                       wr_en;
	logic [IDX_W-1:0]           wr_addr;
	logic [abrt_pkg::TAG_W-1:0] wr_tag;
	logic [abrt_pkg::POS_W-1:0] wr_end;
	logic                       rd_en;
	logic [IDX_W-1:0]           rd_addr;
	logic [abrt_pkg::TAG_W-1:0] rd_tag;
	logic [abrt_pkg::POS_W-1:0] rd_end;
	logic                       out_free;
	logic                       out_load;
	abrt_pkg::result_t          out_res;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			surround_q <= 1'b0;
		end else if (cfg.valid) begin
			surround_q <= cfg.surround_mode;
		end
	end

	abrt_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.surround (surround_q),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_tag   (wr_tag),
		.wr_end   (wr_end),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_tag   (rd_tag),
		.rd_end   (rd_end),
		.out_free (out_free),
		.out_load (out_load),
		.out_res  (out_res)
	);

	abrt_mem #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_tag  (wr_tag),
		.wr_end  (wr_end),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_tag  (rd_tag),
		.rd_end  (rd_end)
	);

	abrt_outreg u_outreg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (out_load),
		.res_in (out_res),
		.free   (out_free),
		.rsp    (rsp)
	);

endmodule

>>> rtl/abrt_checker.sv
// ----------------------------------------------------------------------------
// Audio buffer release tracker port checker
// Watches the result channel for protocol and encoding slips.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "audio_buffer_release_tracker_unit_defines.svh"

module abrt_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       rsp_valid,
	input logic                       rsp_ready,
	input logic [abrt_pkg::TAG_W-1:0] out_tag,
	input logic                       tag_valid,
	input logic                       found,
	input logic                       any_released,
	input logic                       overflow,
	input logic                       last
);

	// A result beat that is not taken stays offered.
	`ABRT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)

	// A popped tag never shares its beat with another command's answer.
	`ABRT_ASSERT_IMPL(a_tag_excl, rsp_valid && tag_valid, !found && !any_released && !overflow)

	// A refused append is a single, final beat without a tag.
	`ABRT_ASSERT_IMPL(a_ovf_last, rsp_valid && overflow, last && !tag_valid)

	// Beats without a popped tag carry a zero tag.
	`ABRT_ASSERT_IMPL(a_tag_zero, rsp_valid && !tag_valid, out_tag == '0)

endmodule

bind audio_buffer_release_tracker_unit abrt_checker u_abrt_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.out_tag      (rsp.out_tag),
	.tag_valid    (rsp.tag_valid),
	.found        (rsp.found),
	.any_released (rsp.any_released),
	.overflow     (rsp.overflow),
	.last         (rsp.last)
);
